// ===== rtl/scp_pkg.sv =====
// shared types, widths and helpers for the staggered conserved-to-primitive converter
// no dependencies; imported by every module of the block
package scp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 48;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int AXIS_W        = 2;
    localparam int ACC_W         = 64;
    localparam int MAG_W         = DATA_W + 1;
    localparam int DIV_W         = ACC_W + FRACTION_BITS;
    localparam int HI_W          = DIV_W - DATA_W;
    localparam int CMP_W         = (HI_W > MAG_W) ? HI_W : MAG_W;
    localparam int STEP_W        = $clog2(DATA_W);
    localparam int MUL_W         = 64;
    localparam int HALF_W        = MUL_W / 2;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int MUL_STEPS     = 4;
    localparam int MSTEP_W       = 3;
    localparam int KE_SHIFT      = 3;

    localparam logic [CFG_W-1:0] HEAT_CAPACITY_RESET = CFG_W'(47055);
    localparam logic [CFG_W-1:0] GAS_CONSTANT_RESET  = CFG_W'(544866);

    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_CONSTANT  = 1'd1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_VL, ST_VH, ST_SQ, ST_KE, ST_IE, ST_TEMP,
        ST_RCR, ST_PRES, ST_RATIO, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_VL, OP_VH, OP_SQ, OP_KE, OP_IE, OP_TEMP, OP_RCR, OP_PRES, OP_RATIO
    } op_t;

    typedef struct packed {
        logic load;
        logic start_div;
        logic start_mul;
        logic capture;
        logic publish;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic is_z;
    } dp_status_t;

    typedef struct packed {
        logic                     fault;
        logic signed [DATA_W-1:0] value;
    } sat_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // clamp a sign and magnitude to the signed data range
    function automatic sat_t sat_data(input logic neg, input logic [ACC_W-1:0] mag,
                                      input logic ovf);
        sat_t              r;
        logic              hi_nz;
        logic [DATA_W-1:0] low;
        hi_nz = |mag[ACC_W-1:DATA_W];
        low   = mag[DATA_W-1:0];
        r.fault = 1'b0;
        if (neg) begin
            if (ovf || hi_nz || (low[DATA_W-1] && (|low[DATA_W-2:0]))) begin
                r.fault = 1'b1;
                r.value = DATA_MIN;
            end
            else begin
                r.value = ~low + 1'b1;
            end
        end
        else begin
            if (ovf || hi_nz || low[DATA_W-1]) begin
                r.fault = 1'b1;
                r.value = DATA_MAX;
            end
            else begin
                r.value = low;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/staggered_conserved_to_primitive.sv =====
// top level: staggered conserved-to-primitive converter, controller plus datapath
// depends on scp_pkg, scp_ctrl, scp_datapath
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | which_axis, densities, momenta, energy, scalar
//  out      | out_valid / out_stall  | axis_echo, velocities, momentum, T, p, ratio, flags
//  config   | cfg_write_en           | cfg_index, cfg_data
//
// one item at a time; the shared divider makes one quotient bit per cycle (48 steps)
// x or y item: two divisions, one multiply of four partial products
// z item: six divisions, three multiplies; zero or overflowing
// divisions skip the quotient bit steps
// reset clears the accumulator, fault flag and handshake state and loads the
// config defaults; a waiting result holds back only the next item's output
module staggered_conserved_to_primitive (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [scp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [scp_pkg::AXIS_W-1:0]         which_axis,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_center,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_below,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_above,
    input  logic signed [scp_pkg::DATA_W-1:0]  mom_low_face,
    input  logic signed [scp_pkg::DATA_W-1:0]  mom_high_face,
    input  logic signed [scp_pkg::DATA_W-1:0]  total_energy,
    input  logic signed [scp_pkg::DATA_W-1:0]  scalar_density,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [scp_pkg::AXIS_W-1:0]         axis_echo,
    output logic signed [scp_pkg::DATA_W-1:0]  face_velocity_low,
    output logic signed [scp_pkg::DATA_W-1:0]  face_velocity_high,
    output logic signed [scp_pkg::DATA_W-1:0]  cell_velocity,
    output logic signed [scp_pkg::DATA_W-1:0]  cell_momentum,
    output logic signed [scp_pkg::DATA_W-1:0]  temperature,
    output logic signed [scp_pkg::DATA_W-1:0]  pressure,
    output logic signed [scp_pkg::DATA_W-1:0]  scalar_ratio,
    output logic                               divide_fault,
    output logic                               last_of_cell
);
    import scp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    scp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    scp_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .which_axis         (which_axis),
        .rho_center         (rho_center),
        .rho_below          (rho_below),
        .rho_above          (rho_above),
        .mom_low_face       (mom_low_face),
        .mom_high_face      (mom_high_face),
        .total_energy       (total_energy),
        .scalar_density     (scalar_density),
        .axis_echo          (axis_echo),
        .face_velocity_low  (face_velocity_low),
        .face_velocity_high (face_velocity_high),
        .cell_velocity      (cell_velocity),
        .cell_momentum      (cell_momentum),
        .temperature        (temperature),
        .pressure           (pressure),
        .scalar_ratio       (scalar_ratio),
        .divide_fault       (divide_fault),
        .last_of_cell       (last_of_cell)
    );

endmodule

// ===== rtl/scp_div.sv =====
// restoring divider, one quotient bit per cycle, saturated signed result
// depends on scp_pkg
module scp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        num_neg,
    input  logic [scp_pkg::DIV_W-1:0]   dividend,
    input  logic                        den_neg,
    input  logic [scp_pkg::MAG_W-1:0]   den_mag,
    output logic                        done,
    output scp_pkg::sat_t               result
);
    import scp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  d_reg;
    logic [DATA_W-1:0] quo_reg;
    logic              neg_reg;
    sat_t              res_reg;

    logic [CMP_W-1:0]  hi_cmp;
    logic              too_big;
    logic [MAG_W:0]    trial;
    logic              ge;
    logic [MAG_W:0]    diff;
    logic [MAG_W-1:0]  rem_next;
    logic [DATA_W-1:0] quo_next;

    always_comb
    begin
        hi_cmp   = CMP_W'(dividend[DIV_W-1:DATA_W]);
        too_big  = hi_cmp >= CMP_W'(den_mag);
        trial    = {rem_reg, quo_reg[DATA_W-1]};
        ge       = trial >= {1'b0, d_reg};
        diff     = trial - {1'b0, d_reg};
        rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (den_mag == '0 || too_big)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num_neg ^ den_neg;
            d_reg   <= den_mag;
            rem_reg <= MAG_W'(hi_cmp);
            quo_reg <= dividend[DATA_W-1:0];
            if (den_mag == '0)
            begin
                res_reg.fault <= 1'b1;
                res_reg.value <= num_neg ? DATA_MIN : DATA_MAX;
            end
            else if (too_big)
            begin
                res_reg <= sat_data(num_neg ^ den_neg, '1, 1'b1);
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_reg == STEP_W'(DATA_W - 1))
            begin
                res_reg <= sat_data(neg_reg, ACC_W'(quo_next), 1'b0);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg || done_reg))
        else $error("divider start neither ran nor finished");

endmodule

// ===== rtl/scp_mul.sv =====
// 64 x 64 unsigned multiplier from four 32 x 32 partial products over cycles
// depends on scp_pkg
module scp_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [scp_pkg::MUL_W-1:0]   a,
    input  logic [scp_pkg::MUL_W-1:0]   b,
    output logic                        done,
    output logic [scp_pkg::PROD_W-1:0]  product
);
    import scp_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [MSTEP_W-1:0]  step_reg;
    logic [MUL_W-1:0]    a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [2*HALF_W-1:0] part_reg;
    logic [1:0]          shift_reg;
    logic [PROD_W-1:0]   acc_reg;

    logic [HALF_W-1:0]   a_part;
    logic [HALF_W-1:0]   b_part;
    logic [PROD_W-1:0]   part_aligned;

    always_comb
    begin
        a_part = step_reg[0] ? a_reg[MUL_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_part = step_reg[1] ? b_reg[MUL_W-1:HALF_W] : b_reg[HALF_W-1:0];
        case (shift_reg)
            2'd1:    part_aligned = {{HALF_W{1'b0}}, part_reg, {HALF_W{1'b0}}};
            2'd2:    part_aligned = {part_reg, {(2*HALF_W){1'b0}}};
            default: part_aligned = {{(2*HALF_W){1'b0}}, part_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == MSTEP_W'(MUL_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // multiply one pair of halves while the previous partial is added in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != MSTEP_W'(MUL_STEPS))
            begin
                part_reg  <= a_part * b_part;
                shift_reg <= {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
            end
            if (step_reg != '0)
            begin
                acc_reg <= acc_reg + part_aligned;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier reports done while still busy");

endmodule

// ===== rtl/scp_datapath.sv =====
// datapath: item and config registers, operand selection, shared divider and
// multiplier, accumulator and result registers; depends on scp_pkg, scp_div, scp_mul
module scp_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scp_pkg::dp_cmd_t                   cmd,
    output scp_pkg::dp_status_t                status,
    input  logic                               cfg_write_en,
    input  logic [scp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]          cfg_data,
    input  logic [scp_pkg::AXIS_W-1:0]         which_axis,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_center,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_below,
    input  logic signed [scp_pkg::DATA_W-1:0]  rho_above,
    input  logic signed [scp_pkg::DATA_W-1:0]  mom_low_face,
    input  logic signed [scp_pkg::DATA_W-1:0]  mom_high_face,
    input  logic signed [scp_pkg::DATA_W-1:0]  total_energy,
    input  logic signed [scp_pkg::DATA_W-1:0]  scalar_density,
    output logic [scp_pkg::AXIS_W-1:0]         axis_echo,
    output logic signed [scp_pkg::DATA_W-1:0]  face_velocity_low,
    output logic signed [scp_pkg::DATA_W-1:0]  face_velocity_high,
    output logic signed [scp_pkg::DATA_W-1:0]  cell_velocity,
    output logic signed [scp_pkg::DATA_W-1:0]  cell_momentum,
    output logic signed [scp_pkg::DATA_W-1:0]  temperature,
    output logic signed [scp_pkg::DATA_W-1:0]  pressure,
    output logic signed [scp_pkg::DATA_W-1:0]  scalar_ratio,
    output logic                               divide_fault,
    output logic                               last_of_cell
);
    import scp_pkg::*;

    logic [CFG_W-1:0]         heat_reg;
    logic [CFG_W-1:0]         gas_reg;
    logic [ACC_W-1:0]         sum_reg;
    logic                     sticky_reg;
    logic                     fault_reg;

    logic [AXIS_W-1:0]        axis_reg;
    logic signed [DATA_W-1:0] rc_reg, rb_reg, ra_reg, ml_reg, mh_reg, en_reg, sd_reg;
    logic signed [DATA_W-1:0] vl_reg, vh_reg, ke_reg, ie_reg, temp_reg;
    logic signed [DATA_W-1:0] rcr_reg, pres_reg, ratio_reg;

    logic [AXIS_W-1:0]        axis_out_reg;
    logic signed [DATA_W-1:0] fvl_out_reg, fvh_out_reg, cv_out_reg, cm_out_reg;
    logic signed [DATA_W-1:0] temp_out_reg, pres_out_reg, ratio_out_reg;
    logic                     fault_out_reg;
    logic                     last_out_reg;

    logic signed [MAG_W-1:0]  num_s;
    logic signed [MAG_W-1:0]  den_s;
    logic                     num_from_sum;
    logic [ACC_W-1:0]         num_mag;
    logic                     num_neg;
    logic [DIV_W-1:0]         dividend;
    logic                     div_done;
    sat_t                     div_res;

    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic                     mul_neg;
    logic                     mul_done;
    logic [PROD_W-1:0]        product;
    logic [ACC_W-1:0]         prod_mid;
    logic                     prod_ovf;
    sat_t                     mul_res;
    logic [ACC_W-1:0]         sq_val;
    logic [ACC_W:0]           sum_wide;

    logic signed [MAG_W-1:0]  msum;
    logic signed [MAG_W-1:0]  vsum;
    logic signed [MAG_W-1:0]  vadj;
    logic signed [MAG_W-1:0]  madj;
    logic                     item_fault;
    logic                     is_z;

    assign is_z = (axis_reg == AXIS_Z);

    // operand selection for the shared units
    always_comb
    begin
        num_s        = '0;
        den_s        = MAG_W'(rc_reg);
        num_from_sum = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        mul_neg      = 1'b0;
        msum         = MAG_W'(ml_reg) + MAG_W'(mh_reg);
        case (cmd.op)
            OP_VL:
            begin
                num_s = $signed({ml_reg, 1'b0});
                den_s = MAG_W'(rc_reg) + MAG_W'(rb_reg);
            end
            OP_VH:
            begin
                num_s = $signed({mh_reg, 1'b0});
                den_s = MAG_W'(ra_reg) + MAG_W'(rc_reg);
            end
            OP_SQ:
            begin
                mul_a = MUL_W'(mag_of(msum));
                mul_b = MUL_W'(mag_of(msum));
            end
            OP_KE:
            begin
                num_from_sum = 1'b1;
            end
            OP_IE:
            begin
                num_s = MAG_W'(en_reg) - MAG_W'(ke_reg);
            end
            OP_TEMP:
            begin
                num_s = MAG_W'(ie_reg);
                den_s = $signed(MAG_W'(heat_reg));
            end
            OP_RCR:
            begin
                mul_a   = MUL_W'(mag_of(MAG_W'(rc_reg)));
                mul_b   = MUL_W'(gas_reg);
                mul_neg = rc_reg[DATA_W-1];
            end
            OP_PRES:
            begin
                mul_a   = MUL_W'(mag_of(MAG_W'(rcr_reg)));
                mul_b   = MUL_W'(mag_of(MAG_W'(temp_reg)));
                mul_neg = rcr_reg[DATA_W-1] ^ temp_reg[DATA_W-1];
            end
            OP_RATIO:
            begin
                num_s = MAG_W'(sd_reg);
            end
            default:
            begin
                num_s = '0;
            end
        endcase
        num_mag  = num_from_sum ? (sum_reg >> KE_SHIFT) : ACC_W'(mag_of(num_s));
        num_neg  = num_from_sum ? 1'b0 : num_s[MAG_W-1];
        dividend = {num_mag, {FRACTION_BITS{1'b0}}};
    end

    scp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .num_neg  (num_neg),
        .dividend (dividend),
        .den_neg  (den_s[MAG_W-1]),
        .den_mag  (mag_of(den_s)),
        .done     (div_done),
        .result   (div_res)
    );

    scp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start_mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (product)
    );

    always_comb
    begin
        prod_mid = product[FRACTION_BITS+ACC_W-1:FRACTION_BITS];
        prod_ovf = |product[PROD_W-1:FRACTION_BITS+ACC_W];
        mul_res  = sat_data(mul_neg, prod_mid, prod_ovf);
        sq_val   = prod_ovf ? '1 : prod_mid;
        sum_wide = {1'b0, sum_reg} + {1'b0, sq_val};
        item_fault = sticky_reg | fault_reg;
        // halve with truncation toward zero
        vsum = MAG_W'(vl_reg) + MAG_W'(vh_reg);
        vadj = vsum + MAG_W'(vsum[MAG_W-1]);
        madj = msum + MAG_W'(msum[MAG_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg   <= HEAT_CAPACITY_RESET;
            gas_reg    <= GAS_CONSTANT_RESET;
            sum_reg    <= '0;
            sticky_reg <= 1'b0;
            fault_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_HEAT_CAPACITY)
                begin
                    heat_reg <= cfg_data;
                end
                if (cfg_index == REG_GAS_CONSTANT)
                begin
                    gas_reg <= cfg_data;
                end
            end
            if (cmd.load)
            begin
                fault_reg <= 1'b0;
                if (which_axis == AXIS_X)
                begin
                    sum_reg    <= '0;
                    sticky_reg <= 1'b0;
                end
            end
            else if (cmd.capture)
            begin
                case (cmd.op)
                    OP_SQ:
                    begin
                        if (sum_wide[ACC_W])
                        begin
                            sum_reg   <= '1;
                            fault_reg <= 1'b1;
                        end
                        else
                        begin
                            sum_reg <= sum_wide[ACC_W-1:0];
                            if (prod_ovf)
                            begin
                                fault_reg <= 1'b1;
                            end
                        end
                    end
                    OP_RCR, OP_PRES:
                    begin
                        if (mul_res.fault)
                        begin
                            fault_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (div_res.fault)
                        begin
                            fault_reg <= 1'b1;
                        end
                    end
                endcase
            end
            else if (cmd.publish)
            begin
                sticky_reg <= item_fault;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            axis_reg <= which_axis;
            rc_reg   <= rho_center;
            rb_reg   <= rho_below;
            ra_reg   <= rho_above;
            ml_reg   <= mom_low_face;
            mh_reg   <= mom_high_face;
            en_reg   <= total_energy;
            sd_reg   <= scalar_density;
        end
        if (cmd.capture)
        begin
            case (cmd.op)
                OP_VL:    vl_reg    <= div_res.value;
                OP_VH:    vh_reg    <= div_res.value;
                OP_KE:    ke_reg    <= div_res.value;
                OP_IE:    ie_reg    <= div_res.value;
                OP_TEMP:  temp_reg  <= div_res.value;
                OP_RCR:   rcr_reg   <= mul_res.value;
                OP_PRES:  pres_reg  <= mul_res.value;
                OP_RATIO: ratio_reg <= div_res.value;
                default:  ;
            endcase
        end
        if (cmd.publish)
        begin
            axis_out_reg  <= axis_reg;
            fvl_out_reg   <= vl_reg;
            fvh_out_reg   <= vh_reg;
            cv_out_reg    <= vadj[MAG_W-1:1];
            cm_out_reg    <= madj[MAG_W-1:1];
            temp_out_reg  <= is_z ? temp_reg : '0;
            pres_out_reg  <= is_z ? pres_reg : '0;
            ratio_out_reg <= is_z ? ratio_reg : '0;
            fault_out_reg <= item_fault;
            last_out_reg  <= is_z;
        end
    end

    assign status.div_done = div_done;
    assign status.mul_done = mul_done;
    assign status.is_z     = is_z;

    assign axis_echo          = axis_out_reg;
    assign face_velocity_low  = fvl_out_reg;
    assign face_velocity_high = fvh_out_reg;
    assign cell_velocity      = cv_out_reg;
    assign cell_momentum      = cm_out_reg;
    assign temperature        = temp_out_reg;
    assign pressure           = pres_out_reg;
    assign scalar_ratio       = ratio_out_reg;
    assign divide_fault       = fault_out_reg;
    assign last_of_cell       = last_out_reg;

    a_z_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && (cmd.op == OP_KE || cmd.op == OP_IE || cmd.op == OP_TEMP ||
                         cmd.op == OP_RCR || cmd.op == OP_PRES || cmd.op == OP_RATIO))
        |-> is_z)
        else $error("cell-level result captured on an item that is not z");

endmodule

// ===== rtl/scp_ctrl.sv =====
// controller: sequences the operations of one item and the handshakes
// depends on scp_pkg
module scp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scp_pkg::dp_cmd_t     cmd,
    input  scp_pkg::dp_status_t  status
);
    import scp_pkg::*;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic   out_valid_reg, out_valid_next;

    op_t    cur_op;
    logic   uses_mul;
    logic   unit_done;
    logic   can_publish;

    always_comb
    begin
        uses_mul = 1'b0;
        case (state_reg)
            ST_VH:    cur_op = OP_VH;
            ST_SQ:
            begin
                cur_op   = OP_SQ;
                uses_mul = 1'b1;
            end
            ST_KE:    cur_op = OP_KE;
            ST_IE:    cur_op = OP_IE;
            ST_TEMP:  cur_op = OP_TEMP;
            ST_RCR:
            begin
                cur_op   = OP_RCR;
                uses_mul = 1'b1;
            end
            ST_PRES:
            begin
                cur_op   = OP_PRES;
                uses_mul = 1'b1;
            end
            ST_RATIO: cur_op = OP_RATIO;
            default:  cur_op = OP_VL;
        endcase
        unit_done   = uses_mul ? status.mul_done : status.div_done;
        can_publish = !out_valid_reg || !out_stall;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_VL;
                end
            end
            ST_DONE:
            begin
                if (can_publish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                end
                else if (unit_done)
                begin
                    started_next = 1'b0;
                    case (state_reg)
                        ST_VL:   state_next = ST_VH;
                        ST_VH:   state_next = ST_SQ;
                        ST_SQ:   state_next = status.is_z ? ST_KE : ST_DONE;
                        ST_KE:   state_next = ST_IE;
                        ST_IE:   state_next = ST_TEMP;
                        ST_TEMP: state_next = ST_RCR;
                        ST_RCR:  state_next = ST_PRES;
                        ST_PRES: state_next = ST_RATIO;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.op   = cur_op;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_DONE:
            begin
                cmd.publish = can_publish;
            end
            default:
            begin
                if (!started_reg)
                begin
                    cmd.start_div = !uses_mul;
                    cmd.start_mul = uses_mul;
                end
                else
                begin
                    cmd.capture = unit_done;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (status.div_done || status.mul_done) |-> started_reg)
        else $error("arithmetic unit finished without a launch");

    a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published item not presented");

endmodule
